// File: hw/rtl/dedup_chunk_rebuild_queue_defines.svh
// ------------------------------------------------------------------------
// Dedup chunk rebuild queue - assertion macros
// Shared property shorthands for the port-level checker.
// ------------------------------------------------------------------------
`ifndef DEDUP_CHUNK_REBUILD_QUEUE_DEFINES_SVH
`define DEDUP_CHUNK_REBUILD_QUEUE_DEFINES_SVH

// same-cycle implication
`define DCRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dcrq_pkg.sv
// ------------------------------------------------------------------------
// Dedup chunk rebuild queue - package
// Shared types, codes and candidate offset tables.
// ------------------------------------------------------------------------
package dcrq_pkg;

  localparam int DEF_CHUNK_SIZE_X = 16;
  localparam int DEF_CHUNK_SIZE_Y = 16;
  localparam int DEF_CHUNK_SIZE_Z = 16;
  localparam int DEF_QUEUE_DEPTH  = 64;

  localparam int CW_COORD = 12;
  localparam int CAND_NUM = 9;

  typedef enum logic [1:0] {
    OP_BLOCK = 2'd0,
    OP_CHUNK = 2'd1,
    OP_TAKE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] block_x;
    logic signed [15:0] block_y;
    logic signed [15:0] block_z;
    logic signed [11:0] chunk_x;
    logic signed [11:0] chunk_y;
    logic signed [11:0] chunk_z;
  } item_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [11:0] cz;
    logic [8:0]  mask;
  } cmd_t;

  typedef struct packed {
    logic signed [11:0] taken_x;
    logic signed [11:0] taken_y;
    logic signed [11:0] taken_z;
    logic               taken_valid;
    logic               queue_empty;
    logic [6:0]         queued_count;
    logic [3:0]         dropped_count;
  } res_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_REM,
    F_CORR,
    F_PUSH
  } fstate_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CAND,
    B_SCAN_RD,
    B_SCAN_CMP,
    B_INSERT,
    B_TAKE_RD,
    B_TAKE_GET,
    B_DONE
  } bstate_t;

  localparam logic [11:0] D_NEG  = 12'hFFF;
  localparam logic [11:0] D_ZERO = 12'h000;
  localparam logic [11:0] D_POS  = 12'h001;

  function automatic logic [11:0] cand_dx(logic blk, logic [3:0] idx);
    logic [11:0] d;
    d = D_ZERO;
    if (blk) begin
      unique case (idx)
        4'd0, 4'd4, 4'd6: d = D_NEG;
        4'd1, 4'd5, 4'd7: d = D_POS;
        default:          d = D_ZERO;
      endcase
    end else begin
      unique case (idx)
        4'd0, 4'd1, 4'd2: d = D_NEG;
        4'd6, 4'd7, 4'd8: d = D_POS;
        default:          d = D_ZERO;
      endcase
    end
    return d;
  endfunction

  function automatic logic [11:0] cand_dz(logic blk, logic [3:0] idx);
    logic [11:0] d;
    d = D_ZERO;
    if (blk) begin
      unique case (idx)
        4'd2, 4'd4, 4'd5: d = D_NEG;
        4'd3, 4'd6, 4'd7: d = D_POS;
        default:          d = D_ZERO;
      endcase
    end else begin
      unique case (idx)
        4'd0, 4'd3, 4'd6: d = D_NEG;
        4'd2, 4'd5, 4'd8: d = D_POS;
        default:          d = D_ZERO;
      endcase
    end
    return d;
  endfunction

endpackage

// File: hw/rtl/dcrq_front.sv
// ------------------------------------------------------------------------
// Dedup chunk rebuild queue - front end
// Accepts items, floor-splits block coordinates, builds candidate commands.
// ------------------------------------------------------------------------
module dcrq_front #(
  parameter int CHUNK_SIZE_X = dcrq_pkg::DEF_CHUNK_SIZE_X,
  parameter int CHUNK_SIZE_Y = dcrq_pkg::DEF_CHUNK_SIZE_Y,
  parameter int CHUNK_SIZE_Z = dcrq_pkg::DEF_CHUNK_SIZE_Z
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dcrq_pkg::item_t in_item,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output dcrq_pkg::cmd_t  cmd
);
  import dcrq_pkg::*;

  localparam int SH = 26;
  localparam int SZ   [3] = '{CHUNK_SIZE_X, CHUNK_SIZE_Y, CHUNK_SIZE_Z};
  localparam int KOFS [3] = '{(32768 + CHUNK_SIZE_X - 1) / CHUNK_SIZE_X,
                              (32768 + CHUNK_SIZE_Y - 1) / CHUNK_SIZE_Y,
                              (32768 + CHUNK_SIZE_Z - 1) / CHUNK_SIZE_Z};
  localparam int RCP  [3] = '{(1 << SH) / CHUNK_SIZE_X,
                              (1 << SH) / CHUNK_SIZE_Y,
                              (1 << SH) / CHUNK_SIZE_Z};

  fstate_t state, state_next;
  item_t   item_r;
  cmd_t    cmd_r;

  logic [15:0] bc    [3];
  logic [17:0] usum  [3];
  logic [16:0] u     [3];
  logic [42:0] prod  [3];
  logic [16:0] q_r   [3];
  logic [9:0]  r_r   [3];
  logic [17:0] qs    [3];
  logic [17:0] rem   [3];
  logic        ge    [3];
  logic [16:0] qc    [3];
  logic [9:0]  rc    [3];
  logic [16:0] cq    [3];
  logic        lo    [3];
  logic        hi    [3];

  always_comb begin
    bc[0] = item_r.block_x;
    bc[1] = item_r.block_y;
    bc[2] = item_r.block_z;
    for (int a = 0; a < 3; a++) begin
      usum[a] = {{2{bc[a][15]}}, bc[a]} + 18'(KOFS[a] * SZ[a]);
      u[a]    = usum[a][16:0];
      qs[a]   = 18'(prod[a][42:SH]) * 18'(SZ[a]);
      rem[a]  = {1'b0, u[a]} - qs[a];
      ge[a]   = (r_r[a] >= 10'(SZ[a]));
      qc[a]   = ge[a] ? q_r[a] + 17'd1 : q_r[a];
      rc[a]   = ge[a] ? r_r[a] - 10'(SZ[a]) : r_r[a];
      cq[a]   = qc[a] - 17'(KOFS[a]);
      lo[a]   = (rc[a] == 10'd0);
      hi[a]   = (rc[a] == 10'(SZ[a] - 1));
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_valid) state_next = F_MUL;
      F_MUL:  state_next = F_REM;
      F_REM:  state_next = F_CORR;
      F_CORR: state_next = F_PUSH;
      F_PUSH: if (cmd_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == F_IDLE);
    cmd_valid = (state == F_PUSH);
    cmd       = cmd_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      item_r <= in_item;
    end
    if (state == F_MUL) begin
      for (int a = 0; a < 3; a++) begin
        prod[a] <= 43'(u[a]) * 43'(RCP[a]);
      end
    end
    if (state == F_REM) begin
      for (int a = 0; a < 3; a++) begin
        q_r[a] <= prod[a][42:SH];
        r_r[a] <= rem[a][9:0];
      end
    end
    if (state == F_CORR) begin
      cmd_r.op <= item_r.op;
      unique case (item_r.op)
        OP_BLOCK: begin
          cmd_r.cx   <= cq[0][11:0];
          cmd_r.cy   <= cq[1][11:0];
          cmd_r.cz   <= cq[2][11:0];
          cmd_r.mask <= {1'b0, hi[0] & hi[2], lo[0] & hi[2], hi[0] & lo[2],
                         lo[0] & lo[2], hi[2], lo[2], hi[0], lo[0]};
        end
        OP_CHUNK: begin
          cmd_r.cx   <= item_r.chunk_x;
          cmd_r.cy   <= item_r.chunk_y;
          cmd_r.cz   <= item_r.chunk_z;
          cmd_r.mask <= '1;
        end
        default: begin
          cmd_r.cx   <= item_r.chunk_x;
          cmd_r.cy   <= item_r.chunk_y;
          cmd_r.cz   <= item_r.chunk_z;
          cmd_r.mask <= '0;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/dcrq_cmd_fifo.sv
// ------------------------------------------------------------------------
// Dedup chunk rebuild queue - command queue
// Two-entry queue between the front end and the back end.
// ------------------------------------------------------------------------
module dcrq_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  dcrq_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output dcrq_pkg::cmd_t rd_cmd
);
  import dcrq_pkg::*;

  cmd_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_cmd   = slot[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= wr_cmd;
    end
  end

endmodule

// File: hw/rtl/dcrq_back.sv
// ------------------------------------------------------------------------
// Dedup chunk rebuild queue - back end
// Holds the chunk queue; scans for duplicates, pushes, pops, reports.
// ------------------------------------------------------------------------
module dcrq_back #(
  parameter int QUEUE_DEPTH = dcrq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  dcrq_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output dcrq_pkg::res_t res
);
  import dcrq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bstate_t state, state_next;

  logic [35:0]   mem [QUEUE_DEPTH];
  logic [35:0]   mem_q;
  logic [AW-1:0] rd_addr;

  cmd_t          cmd_r;
  logic [3:0]    step;
  logic [35:0]   cand;
  logic [35:0]   cand_key;
  logic [AW-1:0] scan_ptr;
  logic [CW-1:0] scan_i;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;
  logic [3:0]    drop;
  logic [35:0]   taken;
  logic          tv;
  logic          blk;
  logic          full;
  logic          load_out;
  logic [CW+6:0] count_ext;
  res_t          res_r;

  function automatic logic [AW-1:0] next_slot(logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign blk  = (cmd_r.op == OP_BLOCK);
  assign full = (count == CW'(QUEUE_DEPTH));
  assign cand_key = {cmd_r.cz + cand_dz(blk, step), cmd_r.cy,
                     cmd_r.cx + cand_dx(blk, step)};
  assign count_ext = {7'd0, count};

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          priority case (cmd.op)
            OP_BLOCK, OP_CHUNK: state_next = B_CAND;
            OP_TAKE:  state_next = (count != '0) ? B_TAKE_RD : B_DONE;
            default:  state_next = B_DONE;
          endcase
        end
      end
      B_CAND: begin
        if (step == 4'(CAND_NUM)) state_next = B_DONE;
        else if (cmd_r.mask[step]) state_next = B_SCAN_RD;
      end
      B_SCAN_RD:  state_next = (scan_i == count) ? B_INSERT : B_SCAN_CMP;
      B_SCAN_CMP: state_next = (mem_q == cand) ? B_CAND : B_SCAN_RD;
      B_INSERT:   state_next = B_CAND;
      B_TAKE_RD:  state_next = B_TAKE_GET;
      B_TAKE_GET: state_next = B_DONE;
      B_DONE:     if (!out_valid || out_ready) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (state == B_IDLE);
    load_out  = (state == B_DONE) && (!out_valid || out_ready);
    rd_addr   = (state == B_TAKE_RD) ? head : scan_ptr;
    res       = res_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == B_INSERT && !full) begin
        tail  <= next_slot(tail);
        count <= count + CW'(1);
      end
      if (state == B_TAKE_GET) begin
        head  <= next_slot(head);
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    if (state == B_INSERT && !full) begin
      mem[tail] <= cand;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        cmd_r <= cmd;
        step  <= '0;
        drop  <= '0;
        tv    <= 1'b0;
        taken <= '0;
      end
      B_CAND: begin
        if (step != 4'(CAND_NUM)) begin
          step <= step + 4'd1;
          cand <= cand_key;
          scan_ptr <= head;
          scan_i   <= '0;
        end
      end
      B_SCAN_CMP: begin
        scan_ptr <= next_slot(scan_ptr);
        scan_i   <= scan_i + CW'(1);
      end
      B_INSERT: begin
        if (full) drop <= drop + 4'd1;
      end
      B_TAKE_GET: begin
        taken <= mem_q;
        tv    <= 1'b1;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      res_r.taken_x       <= taken[11:0];
      res_r.taken_y       <= taken[23:12];
      res_r.taken_z       <= taken[35:24];
      res_r.taken_valid   <= tv;
      res_r.queue_empty   <= (count == '0);
      res_r.queued_count  <= count_ext[6:0];
      res_r.dropped_count <= drop;
    end
  end

endmodule

// File: hw/rtl/dedup_chunk_rebuild_queue.sv
// Flow: the front end steps an item through multiply, remainder, correction and
//   push. For block/chunk items the back end scans the queue for each requested
//   candidate, reading then comparing one entry at a time, and inserts it (or drops
//   it when full) if no duplicate is found; a take reads the head entry, while an
//   empty take or unused op does neither. The duplicate scan sets the rate.
// Reset: synchronous rst empties the queue and clears handshakes; storage kept.
// ------------------------------------------------------------------------
// Dedup chunk rebuild queue - top level
// Deduplicating FIFO of chunk coordinates awaiting rebuild.
// ------------------------------------------------------------------------
module dedup_chunk_rebuild_queue #(
  parameter int CHUNK_SIZE_X = dcrq_pkg::DEF_CHUNK_SIZE_X,
  parameter int CHUNK_SIZE_Y = dcrq_pkg::DEF_CHUNK_SIZE_Y,
  parameter int CHUNK_SIZE_Z = dcrq_pkg::DEF_CHUNK_SIZE_Z,
  parameter int QUEUE_DEPTH  = dcrq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // block_x[15:0] block_y[31:16] block_z[47:32] chunk_x[59:48]
  // chunk_y[71:60] chunk_z[83:72], zero pad [87:84]
  input  logic [87:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // taken_x[11:0] taken_y[23:12] taken_z[35:24] queue_empty[36]
  // queued_count[43:37] dropped_count[47:44]
  output logic [47:0] m_tdata,
  // taken_valid[0]
  output logic [0:0]  m_tuser
);
  import dcrq_pkg::*;

  item_t item;
  cmd_t  f_cmd;
  cmd_t  b_cmd;
  res_t  res;
  logic  f_valid;
  logic  f_ready;
  logic  b_valid;
  logic  b_ready;

  always_comb begin
    item.op      = op_t'(s_tuser);
    item.block_x = s_tdata[15:0];
    item.block_y = s_tdata[31:16];
    item.block_z = s_tdata[47:32];
    item.chunk_x = s_tdata[59:48];
    item.chunk_y = s_tdata[71:60];
    item.chunk_z = s_tdata[83:72];
    m_tdata = {res.dropped_count, res.queued_count, res.queue_empty,
               res.taken_z, res.taken_y, res.taken_x};
    m_tuser = res.taken_valid;
  end

  dcrq_front #(
    .CHUNK_SIZE_X(CHUNK_SIZE_X),
    .CHUNK_SIZE_Y(CHUNK_SIZE_Y),
    .CHUNK_SIZE_Z(CHUNK_SIZE_Z)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (item),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .cmd      (f_cmd)
  );

  dcrq_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_cmd  (f_cmd),
    .rd_valid(b_valid),
    .rd_ready(b_ready),
    .rd_cmd  (b_cmd)
  );

  dcrq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(b_valid),
    .cmd_ready(b_ready),
    .cmd      (b_cmd),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .res      (res)
  );

endmodule

// File: hw/rtl/dcrq_checker.sv
// ------------------------------------------------------------------------
// Dedup chunk rebuild queue - port checker
// Port-level properties of the result stream, bound to the top level.
// ------------------------------------------------------------------------
`include "dedup_chunk_rebuild_queue_defines.svh"

module dcrq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [0:0]  m_tuser
);

  `DCRQ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stall lost")
  `DCRQ_ASSERT_NOW(a_drop_max, m_tvalid, m_tdata[47:44] <= 4'd9, "drop count too high")
  `DCRQ_ASSERT_NOW(a_take_clean, m_tvalid && m_tuser[0], m_tdata[47:44] == 4'd0, "take dropped")
  `DCRQ_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata[35:0] == 36'd0, "stale take")

endmodule

bind dedup_chunk_rebuild_queue dcrq_checker u_dcrq_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
